// ===== hdl/hpet_pkg.sv =====
// Package for the event timer device: action and address codes, register
// reset values and the structs passed between the top level and comparators.
// Depends on nothing; the top level and the comparator import it.
`timescale 1ns / 1ps

package hpet_pkg;

  // Number of comparators and the width of the per-comparator result fields.
  localparam int NumComparators = 3;
  localparam int LineW          = 3;
  localparam int WideW          = (NumComparators > LineW) ? NumComparators : LineW;

  // Actions carried by a request.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Register word addresses, that is byte offset bits 9:3.
  localparam logic [6:0] ADDR_CAP     = 7'h00;
  localparam logic [6:0] ADDR_GCFG    = 7'h02;
  localparam logic [6:0] ADDR_STATUS  = 7'h04;
  localparam logic [6:0] ADDR_COUNTER = 7'h1e;

  // Comparator blocks start at byte offset 0x100, 0x20 bytes each.
  localparam logic [4:0] CMP_SLOT_BASE = 5'd8;
  localparam logic [1:0] WORD_CFG      = 2'd0;
  localparam logic [1:0] WORD_VALUE    = 2'd1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TICK_PERIOD = 3'd0;
  localparam logic [2:0] CFG_LONG_CAP    = 3'd1;
  localparam logic [2:0] CFG_LEGACY_CAP  = 3'd2;
  localparam logic [2:0] CFG_ROUTE_CAP   = 3'd3;
  localparam logic [2:0] CFG_PERIOD_CAP  = 3'd4;
  localparam logic [2:0] CFG_REV_VENDOR  = 3'd5;

  // Configuration register reset values.
  localparam logic [26:0] RST_TICK_PERIOD = 27'd69841279;
  localparam logic        RST_LONG_CAP    = 1'b1;
  localparam logic        RST_LEGACY_CAP  = 1'b1;
  localparam logic [31:0] RST_ROUTE_CAP   = 32'h00ff_ffff;
  localparam logic [2:0]  RST_PERIOD_CAP  = 3'd1;
  localparam logic [23:0] RST_REV_VENDOR  = 24'd1;

  // Writable comparator configuration bits.
  typedef struct packed {
    logic [4:0] route;
    logic       mode32;
    logic       valset;
    logic       periodic;
    logic       enable;
    logic       level;
  } cmp_cfg_t;

  // Controls from the top level to one comparator for the current request.
  typedef struct packed {
    logic        tick;
    logic        wr_cfg;
    logic        wr_value;
    logic [63:0] data;
    logic        long_cap;
    logic        per_cap;
    logic [31:0] route_mask;
    logic [63:0] count;
  } cmp_ctl_t;

  // Status from one comparator back to the top level.
  typedef struct packed {
    cmp_cfg_t    cfg_next;
    logic        match;
    logic [63:0] cfg_word;
    logic [63:0] value_word;
  } cmp_stat_t;

endpackage

// ===== hdl/hpet_if.sv =====
// Channel interfaces of the event timer device: request, response and
// configuration write. Depends on nothing.
`timescale 1ns / 1ps

interface hpet_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  address;
  logic [63:0] write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink (input valid, action, address, write_data, output ready);
endinterface

interface hpet_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic [2:0]  irq_lines;
  logic [2:0]  fired;

  modport source (output valid, read_data, irq_lines, fired, input ready);
  modport sink (input valid, read_data, irq_lines, fired, output ready);
endinterface

interface hpet_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/hpet_timer_device_unit.sv =====
// Top level of the event timer device: request register, main counter,
// general registers, comparator array, read mux and response register.
// Depends on hpet_pkg, hpet_if and hpet_cmp.
//
//   channel | modport | moves
//   --------+---------+---------------------------------------------
//   req     | sink    | tick, register read or register write request
//   rsp     | source  | read data, interrupt lines, fired comparators
//   cfg     | sink    | configuration register write, always ready
//
// One request per cycle sustained while responses are taken. A request waits in the input
// register and is then executed against the device state, with its response captured in
// the output register. Synchronous reset puts the valid flags, configuration, device and
// comparator state at their reset values, but not the request and response data; there
// is no clearing pass. A stalled response holds the execute stage, and the input register
// keeps taking requests while it is empty or draining.
`timescale 1ns / 1ps

module hpet_timer_device_unit
  import hpet_pkg::*;
(
  input logic       clk,
  input logic       rst,
  hpet_req_if.sink  req,
  hpet_rsp_if.source rsp,
  hpet_cfg_if.sink  cfg
);

  // Configuration registers.
  logic [26:0] tick_period_fs;
  logic        long_count_capable;
  logic        legacy_capable;
  logic [31:0] route_capability_mask;
  logic [2:0]  periodic_capable_mask;
  logic [23:0] revision_and_vendor;

  // Input register.
  logic        in_valid;
  logic [1:0]  in_action;
  logic [9:0]  in_address;
  logic [63:0] in_data;

  // Device state.
  logic                      counter_enable;
  logic                      counter_enable_next;
  logic                      legacy_route;
  logic                      legacy_route_next;
  logic [NumComparators-1:0] interrupt_status;
  logic [NumComparators-1:0] interrupt_status_next;
  logic [63:0]               main_counter;
  logic [63:0]               main_counter_next;

  // Response register.
  logic        rsp_valid;
  logic [63:0] rsp_read_data;
  logic [2:0]  rsp_irq_lines;
  logic [2:0]  rsp_fired;

  logic                      exec_go;
  logic                      tick_go;
  logic                      rd_go;
  logic                      wr_go;
  logic [6:0]                word_addr;
  logic                      cmp_region;
  logic [4:0]                cmp_slot;
  logic [1:0]                cmp_word;
  logic [63:0]               cnt_mask;
  logic [63:0]               count_inc;
  logic [63:0]               read_word;
  logic [NumComparators-1:0] match_vec;
  logic [NumComparators-1:0] enable_vec;
  logic [NumComparators-1:0] level_vec;
  logic [NumComparators-1:0] pulse_vec;
  logic [NumComparators-1:0] line_vec;
  logic [WideW-1:0]          line_wide;
  logic [WideW-1:0]          fired_wide;

  cmp_ctl_t  cmp_ctl  [NumComparators];
  cmp_stat_t cmp_stat [NumComparators];

  // Handshakes: execute when the response register is free or draining.
  assign exec_go   = in_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !in_valid || exec_go;
  assign cfg.ready = 1'b1;

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_read_data;
  assign rsp.irq_lines = rsp_irq_lines;
  assign rsp.fired     = rsp_fired;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_fs        <= RST_TICK_PERIOD;
      long_count_capable    <= RST_LONG_CAP;
      legacy_capable        <= RST_LEGACY_CAP;
      route_capability_mask <= RST_ROUTE_CAP;
      periodic_capable_mask <= RST_PERIOD_CAP;
      revision_and_vendor   <= RST_REV_VENDOR;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_TICK_PERIOD: tick_period_fs        <= cfg.data[26:0];
        CFG_LONG_CAP:    long_count_capable    <= cfg.data[0];
        CFG_LEGACY_CAP:  legacy_capable        <= cfg.data[0];
        CFG_ROUTE_CAP:   route_capability_mask <= cfg.data;
        CFG_PERIOD_CAP:  periodic_capable_mask <= cfg.data[2:0];
        CFG_REV_VENDOR:  revision_and_vendor   <= cfg.data[23:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_action  <= req.action;
      in_address <= req.address;
      in_data    <= req.write_data;
    end
  end

  // Decode of the executing request.
  assign tick_go    = exec_go && (in_action == ACT_TICK) && counter_enable;
  assign rd_go      = exec_go && (in_action == ACT_READ);
  assign wr_go      = exec_go && (in_action == ACT_WRITE);
  assign word_addr  = in_address[9:3];
  assign cmp_region = in_address[9:8] != 2'b00;
  assign cmp_slot   = in_address[9:5] - CMP_SLOT_BASE;
  assign cmp_word   = in_address[4:3];

  assign cnt_mask  = long_count_capable ? '1 : {32'h0, 32'hffff_ffff};
  assign count_inc = (main_counter + 64'd1) & cnt_mask;

  // Comparator array.
  for (genvar n = 0; n < NumComparators; n++) begin : g_cmp
    logic sel;
    assign sel = cmp_region && (cmp_slot == 5'(n));

    assign cmp_ctl[n].tick       = tick_go;
    assign cmp_ctl[n].wr_cfg     = wr_go && sel && (cmp_word == WORD_CFG);
    assign cmp_ctl[n].wr_value   = wr_go && sel && (cmp_word == WORD_VALUE);
    assign cmp_ctl[n].data       = in_data;
    assign cmp_ctl[n].long_cap   = long_count_capable;
    assign cmp_ctl[n].per_cap    = (n < 3) ? periodic_capable_mask[n % 3] : 1'b0;
    assign cmp_ctl[n].route_mask = route_capability_mask;
    assign cmp_ctl[n].count      = count_inc;

    hpet_cmp u_cmp (
      .clk  (clk),
      .rst  (rst),
      .ctl  (cmp_ctl[n]),
      .stat (cmp_stat[n])
    );

    assign match_vec[n]  = cmp_stat[n].match;
    assign enable_vec[n] = cmp_stat[n].cfg_next.enable;
    assign level_vec[n]  = cmp_stat[n].cfg_next.level;
  end

  // General registers, status word and main counter.
  always_comb begin
    counter_enable_next   = counter_enable;
    legacy_route_next     = legacy_route;
    interrupt_status_next = interrupt_status;
    main_counter_next     = main_counter;
    if (tick_go) begin
      main_counter_next     = count_inc;
      interrupt_status_next = interrupt_status | (match_vec & enable_vec & level_vec);
    end else if (wr_go && !cmp_region) begin
      case (word_addr)
        ADDR_GCFG: begin
          counter_enable_next = in_data[0];
          legacy_route_next   = in_data[1] & legacy_capable;
        end
        ADDR_STATUS:  interrupt_status_next = interrupt_status & ~in_data[NumComparators-1:0];
        ADDR_COUNTER: main_counter_next     = in_data & cnt_mask;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_enable   <= 1'b0;
      legacy_route     <= 1'b0;
      interrupt_status <= '0;
      main_counter     <= '0;
    end else begin
      counter_enable   <= counter_enable_next;
      legacy_route     <= legacy_route_next;
      interrupt_status <= interrupt_status_next;
      main_counter     <= main_counter_next;
    end
  end

  // Read mux over the register map.
  always_comb begin
    read_word = 64'h0;
    if (cmp_region) begin
      for (int n = 0; n < NumComparators; n++) begin
        if (cmp_slot == 5'(n)) begin
          case (cmp_word)
            WORD_CFG:   read_word = cmp_stat[n].cfg_word;
            WORD_VALUE: read_word = cmp_stat[n].value_word;
            default:    read_word = 64'h0;
          endcase
        end
      end
    end else begin
      case (word_addr)
        ADDR_CAP: read_word = {5'h0, tick_period_fs, revision_and_vendor[23:8],
                               legacy_capable, 1'b0, long_count_capable,
                               5'(NumComparators - 1), revision_and_vendor[7:0]};
        ADDR_GCFG:    read_word = {62'h0, legacy_route, counter_enable};
        ADDR_STATUS:  read_word = 64'(interrupt_status);
        ADDR_COUNTER: read_word = main_counter & cnt_mask;
        default:      read_word = 64'h0;
      endcase
    end
  end

  // Interrupt lines from the updated state, plus one-step edge pulses.
  assign pulse_vec  = tick_go ? (match_vec & enable_vec & ~level_vec) : '0;
  assign line_vec   = (enable_vec & level_vec & interrupt_status_next) | pulse_vec;
  assign line_wide  = WideW'(line_vec);
  assign fired_wide = WideW'(match_vec);

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_read_data <= rd_go ? read_word : 64'h0;
      rsp_irq_lines <= line_wide[LineW-1:0];
      rsp_fired     <= fired_wide[LineW-1:0];
    end
  end

  // A request waiting in the input register is not overwritten.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !exec_go |=> in_valid && $stable(in_action) && $stable(in_address)
      && $stable(in_data))
    else $error("input register changed while its request waited");

  // The halted counter only moves on a register write.
  assert property (@(posedge clk) disable iff (rst)
    !counter_enable && !wr_go |=> $stable(main_counter))
    else $error("main counter moved while halted");

  // Only a tick can report fired comparators.
  assert property (@(posedge clk) disable iff (rst)
    exec_go && (in_action != ACT_TICK) |=> rsp_fired == 3'h0)
    else $error("fired set on a request that is not a tick");

  // Fired comparators come with zero read data.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_fired != 3'h0) |-> rsp_read_data == 64'h0)
    else $error("read data on a tick response");

endmodule

// ===== hdl/hpet_cmp.sv =====
// One timer comparator: its config, compare value and period, the match
// against the advanced counter and the register words it shows.
// Depends on hpet_pkg.
`timescale 1ns / 1ps

module hpet_cmp
  import hpet_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmp_ctl_t  ctl,
  output cmp_stat_t stat
);

  cmp_cfg_t    cfg;
  cmp_cfg_t    cfg_next;
  logic [63:0] value;
  logic [63:0] value_next;
  logic [63:0] period;
  logic [63:0] period_next;
  logic [63:0] width_mask;
  logic [63:0] masked_data;
  logic [4:0]  pin;
  logic        match;

  // A narrow comparator works on the low 32 bits only.
  assign width_mask  = (cfg.mode32 || !ctl.long_cap) ? {32'h0, 32'hffff_ffff} : '1;
  assign masked_data = ctl.data & width_mask;
  assign pin         = ctl.data[13:9];

  // Match against the counter value after this tick's advance.
  assign match = ctl.tick && (((ctl.count ^ value) & width_mask) == 64'h0);

  // Register writes and periodic reload.
  always_comb begin
    cfg_next    = cfg;
    value_next  = value;
    period_next = period;
    if (ctl.wr_cfg) begin
      cfg_next.level    = ctl.data[1];
      cfg_next.enable   = ctl.data[2];
      cfg_next.periodic = ctl.data[3] & ctl.per_cap;
      cfg_next.valset   = ctl.data[6];
      cfg_next.mode32   = ctl.data[8];
      cfg_next.route    = ctl.route_mask[pin] ? pin : cfg.route;
    end else if (ctl.wr_value) begin
      if (cfg.periodic) begin
        if (cfg.valset) begin
          value_next = masked_data;
        end
        period_next = masked_data;
      end else begin
        value_next = masked_data;
      end
      cfg_next.valset = 1'b0;
    end else if (match && cfg.periodic) begin
      value_next = (value + period) & width_mask;
    end
  end

  // Comparator state; reset leaves it disabled and one-shot.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg    <= '0;
      value  <= '1;
      period <= '0;
    end else begin
      cfg    <= cfg_next;
      value  <= value_next;
      period <= period_next;
    end
  end

  // Words seen on a register read, and the status for the top level.
  assign stat.cfg_next   = cfg_next;
  assign stat.match      = match;
  assign stat.cfg_word   = {ctl.route_mask, 18'h0, cfg.route, cfg.mode32, 1'b0, cfg.valset,
                            ctl.long_cap, ctl.per_cap, cfg.periodic, cfg.enable, cfg.level,
                            1'b0};
  assign stat.value_word = value & width_mask;

endmodule
